/* hw/rtl/fspm_pkg.sv */
// fspm_pkg: shared types, codes and default sizes for the frame slot pool manager
// no dependencies; imported by every module of the block but fspm_ram
package fspm_pkg;

  // default sizes, handed to the top level parameters
  localparam int PRODUCERS_DEF = 2;
  localparam int CHANNELS_DEF  = 2;
  localparam int SLOTS_DEF     = 8;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int PROD_ID_W  = 1;
  localparam int CONS_ID_W  = 1;
  localparam int SLOT_NUM_W = 3;
  localparam int FORMAT_W   = 4;
  localparam int DIM_W      = 12;
  localparam int LENGTH_W   = 24;
  localparam int SIU_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int SLOT_IDX_W = 3;
  localparam int SLOT_ST_W  = 2;

  // configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam logic [SIU_W-1:0] SLOTS_IN_USE_RST = 4'd8;

  typedef enum logic [2:0] {
    REG_FORMAT = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_LENGTH = 3'd3,
    REG_SLOTS  = 3'd4
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_NO_FRESH = 2'd2,
    STS_BUSY     = 2'd3
  } status_t;

  typedef enum logic [SLOT_ST_W-1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_FRESH = 2'd1,
    SLOT_STALE = 2'd2
  } slot_st_t;

  typedef struct packed {
    logic [FORMAT_W-1:0] expected_format;
    logic [DIM_W-1:0]    expected_width;
    logic [DIM_W-1:0]    expected_height;
    logic [LENGTH_W-1:0] expected_length;
    logic [SIU_W-1:0]    slots_in_use;
  } cfg_t;

  typedef struct packed {
    logic                  valid;
    status_t               status;
    logic                  channel;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  last;
  } res_t;

endpackage

/* hw/rtl/frame_slot_pool_manager.sv */
// frame_slot_pool_manager: top level with the register file, the sequencer and the result register
// depends on fspm_pkg, fspm_cfg and fspm_seq
//
// usage:
//   apb port sets the expected frame format, width, height, length and the slot count.
//   an item is taken on the in_ channel when in_valid is high and in_stall is low.
//   a write that passes the checks gives one result per channel in channel order, every
//   other item one result; out_last marks the final result of an item.
//   one item at a time: in_stall stays high until its last result is in the output
//   register. a channel scan reads the slots from the pointer up to the first hit or
//   the slot count, all through one slot state ram read port; a write scans each channel
//   in turn. a producer reset sweeps CHANNELS * SLOTS ram entries, one per cycle.
//   after rst_n all PRODUCERS * CHANNELS * SLOTS ram entries (32 by default) are
//   cleared with in_stall high; the apb port works during that pass.
//   a stalled result holds on the out_ ports; the next item can be taken meanwhile
//   and waits at its first result until the register frees.
module frame_slot_pool_manager #(
  parameter int PRODUCERS = fspm_pkg::PRODUCERS_DEF,
  parameter int CHANNELS  = fspm_pkg::CHANNELS_DEF,
  parameter int SLOTS     = fspm_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fspm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fspm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fspm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fspm_pkg::CMD_W-1:0]       in_cmd,
  input  logic [fspm_pkg::PROD_ID_W-1:0]   in_producer_id,
  input  logic [fspm_pkg::CONS_ID_W-1:0]   in_consumer_id,
  input  logic [fspm_pkg::SLOT_NUM_W-1:0]  in_slot_number,
  input  logic [fspm_pkg::FORMAT_W-1:0]    in_frame_format,
  input  logic [fspm_pkg::DIM_W-1:0]       in_frame_width,
  input  logic [fspm_pkg::DIM_W-1:0]       in_frame_height,
  input  logic [fspm_pkg::LENGTH_W-1:0]    in_frame_length,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [fspm_pkg::STATUS_W-1:0]    out_status,
  output logic                             out_channel,
  output logic [fspm_pkg::SLOT_IDX_W-1:0]  out_slot_index,
  output logic                             out_last
);
  import fspm_pkg::*;

  cfg_t                  cfg;
  res_t                  res;
  logic                  res_ready;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic                  out_channel_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic                  out_last_r;

  fspm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fspm_seq #(
    .PRODUCERS (PRODUCERS),
    .CHANNELS  (CHANNELS),
    .SLOTS     (SLOTS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_producer_id  (in_producer_id),
    .in_consumer_id  (in_consumer_id),
    .in_slot_number  (in_slot_number),
    .in_frame_format (in_frame_format),
    .in_frame_width  (in_frame_width),
    .in_frame_height (in_frame_height),
    .in_frame_length (in_frame_length),
    .res             (res),
    .res_ready       (res_ready)
  );

  // output register frees when empty or when its item is taken this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_status_r  <= res.status;
      out_channel_r <= res.channel;
      out_slot_r    <= res.slot_index;
      out_last_r    <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_channel    = out_channel_r;
  assign out_slot_index = out_slot_r;
  assign out_last       = out_last_r;

endmodule

/* hw/rtl/fspm_ram.sv */
// fspm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module fspm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/fspm_cfg.sv */
// fspm_cfg: apb register file holding the frame checks and the slot count
// depends on fspm_pkg
module fspm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fspm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [fspm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fspm_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output fspm_pkg::cfg_t                  cfg
);
  import fspm_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_FORMAT: cfg_nxt.expected_format = pwdata[FORMAT_W-1:0];
        REG_WIDTH:  cfg_nxt.expected_width  = pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.expected_height = pwdata[DIM_W-1:0];
        REG_LENGTH: cfg_nxt.expected_length = pwdata[LENGTH_W-1:0];
        REG_SLOTS:  cfg_nxt.slots_in_use    = pwdata[SIU_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FORMAT: prdata = APB_DATA_W'(cfg_r.expected_format);
      REG_WIDTH:  prdata = APB_DATA_W'(cfg_r.expected_width);
      REG_HEIGHT: prdata = APB_DATA_W'(cfg_r.expected_height);
      REG_LENGTH: prdata = APB_DATA_W'(cfg_r.expected_length);
      REG_SLOTS:  prdata = APB_DATA_W'(cfg_r.slots_in_use);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_format <= '0;
      cfg_r.expected_width  <= '0;
      cfg_r.expected_height <= '0;
      cfg_r.expected_length <= '0;
      cfg_r.slots_in_use    <= SLOTS_IN_USE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hw/rtl/fspm_seq.sv */
// fspm_seq: request sequencer with the slot state ram, pointers and the slot scan unit
// depends on fspm_pkg and fspm_ram
module fspm_seq #(
  parameter int PRODUCERS = fspm_pkg::PRODUCERS_DEF,
  parameter int CHANNELS  = fspm_pkg::CHANNELS_DEF,
  parameter int SLOTS     = fspm_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fspm_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fspm_pkg::CMD_W-1:0]      in_cmd,
  input  logic [fspm_pkg::PROD_ID_W-1:0]  in_producer_id,
  input  logic [fspm_pkg::CONS_ID_W-1:0]  in_consumer_id,
  input  logic [fspm_pkg::SLOT_NUM_W-1:0] in_slot_number,
  input  logic [fspm_pkg::FORMAT_W-1:0]   in_frame_format,
  input  logic [fspm_pkg::DIM_W-1:0]      in_frame_width,
  input  logic [fspm_pkg::DIM_W-1:0]      in_frame_height,
  input  logic [fspm_pkg::LENGTH_W-1:0]   in_frame_length,
  output fspm_pkg::res_t                  res,
  input  logic                            res_ready
);
  import fspm_pkg::*;

  localparam int NPC  = PRODUCERS * CHANNELS;
  localparam int TOT  = NPC * SLOTS;
  localparam int PI_W = (NPC > 1) ? $clog2(NPC) : 1;
  localparam int AW   = $clog2(TOT);
  localparam int SW   = $clog2(SLOTS);
  localparam int NW   = $clog2(SLOTS + 1);
  localparam int XW   = ((NW > SIU_W) ? NW : SIU_W) + 1;
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SETUP = 5'b00100,
    S_SCAN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  function automatic logic [SLOT_IDX_W-1:0] slot_out(input logic [SW-1:0] s);
    logic [SW+SLOT_IDX_W-1:0] t;
    t = (SW + SLOT_IDX_W)'(s);
    return t[SLOT_IDX_W-1:0];
  endfunction

  state_t                 state_r, state_nxt;
  logic                   zero_r, zero_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [PROD_ID_W-1:0]   prod_r, prod_nxt;
  logic [CIW-1:0]         c_r, c_nxt;
  logic [NW-1:0]          i_r, i_nxt;
  logic                   pend_r, pend_nxt;
  logic [SW-1:0]          pend_idx_r, pend_idx_nxt;
  logic                   have_fresh_r, have_fresh_nxt;
  logic [SW-1:0]          fresh_idx_r, fresh_idx_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW-1:0]          end_r, end_nxt;
  status_t                res_status_r, res_status_nxt;
  logic                   res_chan_r, res_chan_nxt;
  logic [SLOT_IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic                   res_last_r, res_last_nxt;
  logic [SW-1:0]          wp_r [NPC];
  logic [SW-1:0]          wp_nxt [NPC];
  logic [SW-1:0]          rp_r [NPC];
  logic [SW-1:0]          rp_nxt [NPC];

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SLOT_ST_W-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SLOT_ST_W-1:0]   ram_rdata;

  logic [XW-1:0]          siu_x, n_x;
  logic [NW-1:0]          n;
  cmd_t                   in_cmd_e;
  logic                   bad_prod, bad_cons, bad_slot, frame_ok;
  logic [PI_W-1:0]        cur_pi;
  logic [AW-1:0]          cur_base;
  slot_st_t               rd_st;
  logic                   is_write, hit_empty, hit_fresh, term, issue, scan_done;
  logic                   found;
  logic [SW-1:0]          sel_idx;
  logic [NW-1:0]          sel_p1;
  logic [SW-1:0]          new_ptr;
  logic                   last_chan;

  // effective slot count, saturated to 2..SLOTS
  assign siu_x = XW'(cfg.slots_in_use);
  assign n_x   = (siu_x < XW'(2)) ? XW'(2) : ((siu_x > XW'(SLOTS)) ? XW'(SLOTS) : siu_x);
  assign n     = NW'(n_x);

  assign in_cmd_e = cmd_t'(in_cmd);
  assign bad_prod = 32'(in_producer_id) >= 32'(PRODUCERS);
  assign bad_cons = 32'(in_consumer_id) >= 32'(CHANNELS);
  assign bad_slot = XW'(in_slot_number) >= n_x;
  assign frame_ok = (in_frame_format == cfg.expected_format) &&
                    (in_frame_width  == cfg.expected_width)  &&
                    (in_frame_height == cfg.expected_height) &&
                    (in_frame_length == cfg.expected_length);

  assign cur_pi   = PI_W'(32'(prod_r) * CHANNELS + 32'(c_r));
  assign cur_base = AW'(32'(cur_pi) * SLOTS);
  assign ram_raddr = AW'(32'(cur_base) + 32'(i_r));

  // scan unit: one slot read issued per cycle, its state compared in the next cycle
  assign rd_st     = slot_st_t'(ram_rdata);
  assign is_write  = (cmd_r == CMD_WRITE);
  assign hit_empty = (state_r == S_SCAN) && pend_r && (rd_st == SLOT_EMPTY);
  assign hit_fresh = (state_r == S_SCAN) && pend_r && (rd_st == SLOT_FRESH);
  assign term      = is_write ? hit_empty : hit_fresh;
  assign issue     = (state_r == S_SCAN) && !term && (i_r < n);
  assign scan_done = (state_r == S_SCAN) && (term || (i_r >= n));
  assign last_chan = (c_r == CIW'(CHANNELS - 1));

  always_comb begin
    found   = 1'b0;
    sel_idx = pend_idx_r;
    if (is_write) begin
      if (hit_empty) begin
        found = 1'b1;
      end else if (have_fresh_r) begin
        found   = 1'b1;
        sel_idx = fresh_idx_r;
      end else if (hit_fresh) begin
        found = 1'b1;
      end
    end else begin
      found = hit_fresh;
    end
  end

  assign sel_p1  = NW'(sel_idx) + NW'(1);
  assign new_ptr = (sel_p1 == n) ? '0 : SW'(sel_p1);

  always_comb begin
    state_nxt      = state_r;
    zero_nxt       = zero_r;
    cmd_nxt        = cmd_r;
    prod_nxt       = prod_r;
    c_nxt          = c_r;
    i_nxt          = i_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    have_fresh_nxt = have_fresh_r;
    fresh_idx_nxt  = fresh_idx_r;
    clr_nxt        = clr_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_chan_nxt   = res_chan_r;
    res_slot_nxt   = res_slot_r;
    res_last_nxt   = res_last_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_r;
    ram_wdata      = SLOT_EMPTY;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (clr_r == end_r) begin
          zero_nxt = 1'b0;
          if (zero_r) begin
            res_status_nxt = STS_OK;
            res_chan_nxt   = 1'b0;
            res_slot_nxt   = '0;
            res_last_nxt   = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd_e;
          prod_nxt       = in_producer_id;
          c_nxt          = CIW'(in_consumer_id);
          res_status_nxt = STS_INVALID;
          res_chan_nxt   = in_consumer_id;
          res_slot_nxt   = '0;
          res_last_nxt   = 1'b1;
          state_nxt      = S_EMIT;
          if (bad_prod) begin
            res_chan_nxt = (in_cmd_e inside {CMD_READ, CMD_RELEASE}) ? in_consumer_id : 1'b0;
          end else begin
            case (in_cmd_e)
              CMD_WRITE: begin
                res_chan_nxt = 1'b0;
                if (frame_ok) begin
                  c_nxt     = '0;
                  state_nxt = S_SETUP;
                end
              end
              CMD_RESET: begin
                for (int c = 0; c < CHANNELS; c++) begin
                  wp_nxt[PI_W'(32'(in_producer_id) * CHANNELS + c)] = '0;
                  rp_nxt[PI_W'(32'(in_producer_id) * CHANNELS + c)] = '0;
                end
                clr_nxt   = AW'(32'(in_producer_id) * CHANNELS * SLOTS);
                end_nxt   = AW'(32'(in_producer_id) * CHANNELS * SLOTS + CHANNELS * SLOTS - 1);
                zero_nxt  = 1'b1;
                state_nxt = S_CLEAR;
              end
              CMD_READ: begin
                if (!bad_cons) begin
                  state_nxt = S_SETUP;
                end
              end
              default: begin
                // release
                if (!bad_cons && !bad_slot) begin
                  ram_we         = 1'b1;
                  ram_waddr      = AW'((32'(in_producer_id) * CHANNELS + 32'(in_consumer_id))
                                       * SLOTS + 32'(in_slot_number));
                  ram_wdata      = SLOT_EMPTY;
                  res_status_nxt = STS_OK;
                end
              end
            endcase
          end
        end
      end

      S_SETUP: begin
        i_nxt          = is_write ? NW'(wp_r[cur_pi]) : NW'(rp_r[cur_pi]);
        pend_nxt       = 1'b0;
        have_fresh_nxt = 1'b0;
        state_nxt      = S_SCAN;
      end

      S_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          pend_idx_nxt = SW'(i_r);
          i_nxt        = i_r + NW'(1);
        end
        if (hit_fresh && !have_fresh_r) begin
          have_fresh_nxt = 1'b1;
          fresh_idx_nxt  = pend_idx_r;
        end
        if (scan_done) begin
          res_chan_nxt = c_r[0];
          res_last_nxt = is_write ? last_chan : 1'b1;
          state_nxt    = S_EMIT;
          if (found) begin
            ram_we         = 1'b1;
            ram_waddr      = AW'(32'(cur_base) + 32'(sel_idx));
            ram_wdata      = is_write ? SLOT_FRESH : SLOT_STALE;
            res_status_nxt = STS_OK;
            res_slot_nxt   = slot_out(sel_idx);
            if (is_write) begin
              wp_nxt[cur_pi] = new_ptr;
            end else begin
              rp_nxt[cur_pi] = new_ptr;
            end
          end else begin
            res_status_nxt = is_write ? STS_BUSY : STS_NO_FRESH;
            res_slot_nxt   = '0;
          end
        end
      end

      S_EMIT: begin
        if (res_ready) begin
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            c_nxt     = c_r + CIW'(1);
            state_nxt = S_SETUP;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      zero_r  <= 1'b0;
      clr_r   <= '0;
      end_r   <= AW'(TOT - 1);
      pend_r  <= 1'b0;
      for (int k = 0; k < NPC; k++) begin
        wp_r[k] <= '0;
        rp_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      zero_r  <= zero_nxt;
      clr_r   <= clr_nxt;
      end_r   <= end_nxt;
      pend_r  <= pend_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    prod_r       <= prod_nxt;
    c_r          <= c_nxt;
    i_r          <= i_nxt;
    pend_idx_r   <= pend_idx_nxt;
    have_fresh_r <= have_fresh_nxt;
    fresh_idx_r  <= fresh_idx_nxt;
    res_status_r <= res_status_nxt;
    res_chan_r   <= res_chan_nxt;
    res_slot_r   <= res_slot_nxt;
    res_last_r   <= res_last_nxt;
  end

  fspm_ram #(
    .WIDTH (SLOT_ST_W),
    .DEPTH (TOT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);

  assign res.valid      = (state_r == S_EMIT);
  assign res.status     = res_status_r;
  assign res.channel    = res_chan_r;
  assign res.slot_index = res_slot_r;
  assign res.last       = res_last_r;

endmodule
